[hw/rtl/min_heap_priority_queue_core_defines.svh]
// Assertion macros of the priority queue checker.
`ifndef MIN_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Checked only outside reset.
`define MHPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MHPQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/mhpq_pkg.sv]
// Shared types and codes of the min-heap priority queue.
package mhpq_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 11;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [1:0]                status_type;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   localparam status_type STAT_INSERTED  = 2'd0;
   localparam status_type STAT_EXTRACTED = 2'd1;
   localparam status_type STAT_EMPTY     = 2'd2;
   localparam status_type STAT_FULL      = 2'd3;

endpackage

[hw/rtl/min_heap_priority_queue_core.sv]
// Binary min-heap priority queue over signed 32-bit values.
//
// Request channel: an item (req_opcode, req_value) is taken at a rising edge
// where start is high and busy is low. Opcode insert adds req_value; opcode
// extract removes and returns the smallest entry held.
// Response channel: every item gives exactly one response, shown for one cycle
// with rsp_strobe high: the extracted value (zero otherwise), a status code and
// the number of entries held after the item. The receiver cannot stall it.
// An insert on a full queue, an insert into an empty queue and an extract from
// an empty queue respond in the cycle after the item is taken. Any other
// insert moves up level by level until its parent is not larger or it reaches
// the root. An extract reads the root, then the last entry, and ends there if
// it leaves no entry or one. Otherwise it moves down level by level from the
// root until it reaches a leaf or no child is smaller. Each level of an insert
// is one read and compare of the parent; each level of an extract is one read
// of each child and one compare, both paced by the single read port of the
// heap store.
// busy is high after an item's acceptance until its response is shown, but stays
// low for the three quick cases above; a new item may start in the response cycle.
// Reset empties the queue at once; the store itself is not cleared.
module min_heap_priority_queue_core
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_opcode,
   input  value_type  req_value,
   output logic       rsp_strobe,
   output value_type  rsp_out_value,
   output status_type rsp_status,
   output count_type  rsp_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = AW + 1;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_UP_CMP  = 3'd1;
   localparam logic [2:0] S_FIN     = 3'd2;
   localparam logic [2:0] S_X_ROOT  = 3'd3;
   localparam logic [2:0] S_X_LAST  = 3'd4;
   localparam logic [2:0] S_DN_LEFT = 3'd5;
   localparam logic [2:0] S_DN_CMP  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] num_ff, num_in;
   value_type     moving_ff, moving_in;
   value_type     left_ff, left_in;
   value_type     result_ff, result_in;
   logic          op_ff, op_in;
   logic          has_right_ff, has_right_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   value_type     rsp_value_ff, rsp_value_in;
   status_type    rsp_status_ff, rsp_status_in;
   count_type     rsp_count_ff, rsp_count_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   value_type     wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   value_type     rd_data;

   logic          done;
   status_type    done_status;
   value_type     done_value;
   logic [AW-1:0] parent;
   logic [KW-1:0] kid_l;
   logic [KW-1:0] kid_r;
   logic [KW-1:0] next_kid;
   logic          take_r;
   value_type     best;
   logic [AW-1:0] best_idx;

   function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
      logic [AW-1:0] d;
      d = p - AW'(1);
      return d >> 1;
   endfunction

   mhpq_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      num_in       = num_ff;
      moving_in    = moving_ff;
      left_in      = left_ff;
      result_in    = result_ff;
      op_in        = op_ff;
      has_right_in = has_right_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = moving_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      done         = 1'b0;
      done_status  = STAT_INSERTED;
      done_value   = '0;
      parent       = parent_of(pos_ff);
      kid_l        = {pos_ff, 1'b1};
      kid_r        = kid_l + KW'(1);
      take_r       = has_right_ff && (rd_data < left_ff);
      best         = take_r ? rd_data : left_ff;
      best_idx     = take_r ? kid_r[AW-1:0] : kid_l[AW-1:0];
      next_kid     = {best_idx, 1'b1};

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = req_opcode;
               if (req_opcode == OP_INSERT) begin
                  if (num_ff == CW'(CAPACITY)) begin
                     done        = 1'b1;
                     done_status = STAT_FULL;
                  end else begin
                     num_in    = num_ff + CW'(1);
                     moving_in = req_value;
                     pos_in    = AW'(num_ff);
                     if (num_ff == '0) begin
                        wr_en       = 1'b1;
                        wr_addr     = '0;
                        wr_data     = req_value;
                        done        = 1'b1;
                        done_status = STAT_INSERTED;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = parent_of(AW'(num_ff));
                        state_in = S_UP_CMP;
                     end
                  end
               end else begin
                  if (num_ff == '0) begin
                     done        = 1'b1;
                     done_status = STAT_EMPTY;
                  end else begin
                     num_in   = num_ff - CW'(1);
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = S_X_ROOT;
                  end
               end
            end
         end
         S_UP_CMP: begin
            if (moving_ff < rd_data) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff;
               wr_data = rd_data;
               pos_in  = parent;
               if (parent == '0) begin
                  state_in = S_FIN;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = parent_of(parent);
               end
            end else begin
               wr_en       = 1'b1;
               done        = 1'b1;
               done_status = STAT_INSERTED;
               state_in    = S_IDLE;
            end
         end
         S_FIN: begin
            wr_en    = 1'b1;
            done     = 1'b1;
            state_in = S_IDLE;
            if (op_ff == OP_EXTRACT) begin
               done_status = STAT_EXTRACTED;
               done_value  = result_ff;
            end else begin
               done_status = STAT_INSERTED;
            end
         end
         S_X_ROOT: begin
            result_in = rd_data;
            if (num_ff == '0) begin
               done        = 1'b1;
               done_status = STAT_EXTRACTED;
               done_value  = rd_data;
               state_in    = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(num_ff);
               state_in = S_X_LAST;
            end
         end
         S_X_LAST: begin
            moving_in = rd_data;
            pos_in    = '0;
            if (KW'(num_ff) <= KW'(1)) begin
               wr_en       = 1'b1;
               wr_addr     = '0;
               wr_data     = rd_data;
               done        = 1'b1;
               done_status = STAT_EXTRACTED;
               done_value  = result_ff;
               state_in    = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(1);
               state_in = S_DN_LEFT;
            end
         end
         S_DN_LEFT: begin
            left_in      = rd_data;
            has_right_in = kid_r < KW'(num_ff);
            if (kid_r < KW'(num_ff)) begin
               rd_en   = 1'b1;
               rd_addr = kid_r[AW-1:0];
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (best < moving_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff;
               wr_data = best;
               pos_in  = best_idx;
               if (next_kid >= KW'(num_ff)) begin
                  state_in = S_FIN;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = next_kid[AW-1:0];
                  state_in = S_DN_LEFT;
               end
            end else begin
               wr_en       = 1'b1;
               done        = 1'b1;
               done_status = STAT_EXTRACTED;
               done_value  = result_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_strobe_in = done;
      rsp_status_in = done ? done_status : rsp_status_ff;
      rsp_value_in  = done ? done_value : rsp_value_ff;
      rsp_count_in  = done ? COUNT_W'(num_in) : rsp_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         num_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_ff        <= num_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      moving_ff     <= moving_in;
      left_ff       <= left_in;
      result_ff     <= result_in;
      op_ff         <= op_in;
      has_right_ff  <= has_right_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = rsp_count_ff;

endmodule

[hw/rtl/mhpq_ram.sv]
// Heap store: one write port and one read port with registered read data.
module mhpq_ram
   import mhpq_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  value_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output value_type     rd_data
);

   value_type store_ff [DEPTH];
   value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mhpq_checker.sv]
// Port-level checker of the priority queue and its bind to the top level.
`include "min_heap_priority_queue_core_defines.svh"

module mhpq_checker
   import mhpq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input value_type  rsp_out_value,
   input status_type rsp_status,
   input count_type  rsp_count
);

   `MHPQ_ASSERT_ALWAYS(a_reset_idle, reset |=> !busy && !rsp_strobe, "queue not idle after reset")
   `MHPQ_ASSERT(a_accept_progress, start && !busy |=> busy || rsp_strobe, "accepted item stalled")
   `MHPQ_ASSERT(a_resp_not_busy, rsp_strobe |-> !busy, "busy while a response is shown")
   `MHPQ_ASSERT(a_value_zero, rsp_strobe && rsp_status != STAT_EXTRACTED |-> rsp_out_value == '0, "nonzero value without extract")
   `MHPQ_ASSERT(a_empty_count, rsp_strobe && rsp_status == STAT_EMPTY |-> rsp_count == '0, "empty response with nonzero count")

endmodule

bind min_heap_priority_queue_core mhpq_checker u_checker (.*);

[verif/tb_top.sv]
// Self-checking testbench for the min-heap priority queue core with a heap-tracking scoreboard.
module tb_top
   import mhpq_pkg::*;
();

   localparam int CAPACITY = 1024;
   localparam int ITEM_TOTAL = 1550;

   typedef struct {
      value_type  out_value;
      status_type status;
      count_type  count;
   } heap_rsp_type;

   class heap_tracker;
      int           depth;
      value_type    heap_mem[];
      int           occupancy;
      heap_rsp_type pending_rsp[$];
      int           errors;
      int           n_items;
      int           n_checked;
      int           n_full;
      int           n_empty;
      int           peak;

      function new(int slots);
         depth     = slots;
         heap_mem  = new[slots];
         occupancy = 0;
         errors    = 0;
         n_items   = 0;
         n_checked = 0;
         n_full    = 0;
         n_empty   = 0;
         peak      = 0;
      endfunction

      // Applies one accepted item to the tracked heap and queues the response it must give.
      function void note_item(logic op, value_type val);
         heap_rsp_type exp;
         int           pos;
         int           parent;
         int           kid;
         value_type    moving;
         exp.out_value = '0;
         n_items++;
         if (op == OP_INSERT) begin
            if (occupancy >= depth) begin
               exp.status = STAT_FULL;
            end else begin
               pos = occupancy;
               while (pos > 0) begin
                  parent = (pos - 1) / 2;
                  if (!(val < heap_mem[parent])) break;
                  heap_mem[pos] = heap_mem[parent];
                  pos = parent;
               end
               heap_mem[pos] = val;
               occupancy++;
               exp.status = STAT_INSERTED;
            end
         end else begin
            if (occupancy == 0) begin
               exp.status = STAT_EMPTY;
            end else begin
               exp.out_value = heap_mem[0];
               occupancy--;
               if (occupancy > 0) begin
                  moving = heap_mem[occupancy];
                  pos = 0;
                  forever begin
                     kid = 2 * pos + 1;
                     if (kid >= occupancy) break;
                     if (kid + 1 < occupancy && heap_mem[kid + 1] < heap_mem[kid]) kid++;
                     if (!(heap_mem[kid] < moving)) break;
                     heap_mem[pos] = heap_mem[kid];
                     pos = kid;
                  end
                  heap_mem[pos] = moving;
               end
               exp.status = STAT_EXTRACTED;
            end
         end
         exp.count = count_type'(occupancy);
         if (occupancy > peak) peak = occupancy;
         if (exp.status == STAT_FULL) n_full++;
         if (exp.status == STAT_EMPTY) n_empty++;
         pending_rsp.push_back(exp);
      endfunction

      function void check_response(value_type out_value, status_type status, count_type count);
         heap_rsp_type exp;
         if (pending_rsp.size() == 0) begin
            $error("response with no item outstanding: value %0d status %0d count %0d",
                   out_value, status, count);
            errors++;
            return;
         end
         exp = pending_rsp.pop_front();
         n_checked++;
         if (out_value !== exp.out_value) begin
            $error("rsp_out_value: expected %0d, got %0d", exp.out_value, out_value);
            errors++;
         end
         if (status !== exp.status) begin
            $error("rsp_status: expected %0d, got %0d", exp.status, status);
            errors++;
         end
         if (count !== exp.count) begin
            $error("rsp_count: expected %0d, got %0d", exp.count, count);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_opcode = OP_INSERT;
   value_type  req_value = '0;
   logic       rsp_strobe;
   value_type  rsp_out_value;
   status_type rsp_status;
   count_type  rsp_count;

   heap_tracker sb;
   bit no_idle = 1'b0;

   min_heap_priority_queue_core #(.CAPACITY(CAPACITY)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_out_value(rsp_out_value),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_response(rsp_out_value, rsp_status, rsp_count);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic value_type pick_value();
      int r;
      int v;
      r = $urandom_range(99);
      if (r < 45) return value_type'($urandom());
      if (r < 80) begin
         v = int'($urandom_range(16)) - 8;
         return value_type'(v);
      end
      case ($urandom_range(4))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'sh0000_0000;
         3: return -32'sd1;
         default: return 32'sd1;
      endcase
   endfunction

   task automatic send_item(input logic op, input value_type val);
      int gap;
      start      <= 1'b1;
      req_opcode <= op;
      req_value  <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_item(op, val);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic send_biased(input int insert_pct);
      if ($urandom_range(99) < insert_pct) send_item(OP_INSERT, pick_value());
      else send_item(OP_EXTRACT, pick_value());
      if (sb.n_items % 64 == 0) no_idle = ($urandom_range(3) == 0);
   endtask

   initial begin
      #(12 * 600000);
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      sb = new(CAPACITY);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_EXTRACT, 32'sh7fff_ffff);
      send_item(OP_INSERT, 32'sh7fff_ffff);
      send_item(OP_EXTRACT, 32'sh0000_0000);
      send_item(OP_INSERT, 32'sh7fff_ffff);
      send_item(OP_INSERT, 32'sh8000_0000);
      send_item(OP_INSERT, 32'sh0000_0000);
      send_item(OP_INSERT, -32'sd1);
      send_item(OP_INSERT, 32'sd1);
      send_item(OP_INSERT, -32'sd1);
      send_item(OP_INSERT, 32'sh5555_5555);
      send_item(OP_INSERT, 32'shaaaa_aaaa);
      repeat (9) send_item(OP_EXTRACT, 32'shffff_ffff);
      send_item(OP_EXTRACT, 32'sh5555_5555);
      wait_for_drain();

      repeat (150) send_biased(50);
      while (sb.occupancy < CAPACITY) send_biased(95);
      repeat (24) send_biased(60);
      wait_for_drain();
      while (sb.n_items < ITEM_TOTAL) send_biased(20);

      wait_for_drain();
      repeat (40) @(posedge clock);
      if (sb.pending_rsp.size() != 0) begin
         $error("%0d responses never arrived", sb.pending_rsp.size());
         sb.errors++;
      end

      $display("tb_top: %0d items sent, %0d responses checked, peak occupancy %0d of %0d",
               sb.n_items, sb.n_checked, sb.peak, CAPACITY);
      $display("tb_top: %0d inserts refused on a full queue, %0d extracts on an empty queue",
               sb.n_full, sb.n_empty);
      if (sb.errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end
endmodule
